// ----- rtl/core/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int NUM_PAGES  = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_SLOTS  = 512;

  localparam int PAGE_W  = 4;
  localparam int SLOT_W  = 9;
  localparam int CNT_W   = 10;
  localparam int LINK_W  = 5;
  localparam int OFS_W   = 12;
  localparam int SIZE_W  = 14;
  localparam int FIRST_W = 13;
  localparam int ACC_W   = 15;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {PAGE_W{1'b0}}};

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOMEM = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  localparam logic [CIDX_W-1:0] REG_OBJECT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ALIGN  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEADER = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_FREE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ASEL, ST_CARVE, ST_POPRD, ST_POP, ST_RM, ST_INS,
    ST_FCHK, ST_FDEC, ST_FEMP, ST_RECL, ST_OFS
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] object_bytes;
    logic [CFG_W-1:0] align_bytes;
    logic [8:0]       header_bytes;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [FIRST_W-1:0] first;
  } geom_t;

  function automatic logic [1:0] head_idx(kind_t k);
    return 2'(k - 2'd1);
  endfunction

endpackage

// ----- rtl/core/soa_ram.sv -----
// ----------------------------------------------------------------------------
// soa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module soa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/soa_geom.sv -----
// ----------------------------------------------------------------------------
// soa_geom
// Slab geometry: effective alignment, rounded object size, first offset.
// ----------------------------------------------------------------------------
module soa_geom (
  input  soa_pkg::cfg_t  cfg,
  output soa_pkg::geom_t geom
);
  import soa_pkg::*;

  logic [CFG_W-1:0]  eff_a;
  logic [SIZE_W-1:0] amask;

  always_comb begin
    eff_a = CFG_W'(8);
    if (cfg.align_bytes != '0) begin
      for (int i = 0; i < CFG_W; i++) begin
        if (cfg.align_bytes[i]) begin
          eff_a = CFG_W'(1) << i;
        end
      end
    end
    amask      = SIZE_W'(eff_a) - SIZE_W'(1);
    geom.size  = (SIZE_W'(cfg.object_bytes) + amask) & ~amask;
    geom.first = FIRST_W'((SIZE_W'(cfg.header_bytes) + amask) & ~amask);
  end

endmodule

// ----- rtl/core/slab_object_allocator.sv -----
// ----------------------------------------------------------------------------
// slab_object_allocator
// One object cache over a pool of pages with partial, full and free lists.
// ----------------------------------------------------------------------------
// An alloc or free item is taken only while the sequencer is idle. A
// rejected free goes from the check straight to the result; a valid free
// adds the list moves and the reclaim of a spare empty slab. An alloc from
// an existing slab reads the slot-link RAM and moves the slab between lists
// when it fills or leaves the free list; a failed alloc goes to the result
// after slab selection, or after a carve attempt when a page is free but
// holds zero objects. An alloc that carves a new page first sweeps one slot
// a cycle through the slot-link RAM, over the slot count of the page (at
// most 512). The result sits in an output register, so the next item may
// enter while it waits; a stalled result holds the following item in its
// output state.
module slab_object_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rel_page[3:0], free_slot[12:4]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // page_index[3:0], slot_index[12:4], object_offset[24:13]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import soa_pkg::*;

  localparam int ADDR_W = PAGE_W + SLOT_W;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  cfg_t   cfg_r, cfg_nxt;
  geom_t  geom;

  logic               op_r, op_nxt, ins_r, ins_nxt;
  logic [PAGE_W-1:0]  fp_r, fp_nxt, p_r, p_nxt;
  logic [SLOT_W-1:0]  s_r, s_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [4:0]         emp_r, emp_nxt;
  logic [1:0]         stat_r, stat_nxt;
  kind_t              tgt_r, tgt_nxt;

  logic               owned_r [NUM_PAGES], owned_nxt [NUM_PAGES];
  kind_t              kind_r  [NUM_PAGES], kind_nxt  [NUM_PAGES];
  logic [CNT_W-1:0]   inuse_r [NUM_PAGES], inuse_nxt [NUM_PAGES];
  logic [CNT_W-1:0]   total_r [NUM_PAGES], total_nxt [NUM_PAGES];
  logic [FIRST_W-1:0] first_r [NUM_PAGES], first_nxt [NUM_PAGES];
  logic [SIZE_W-1:0]  size_r  [NUM_PAGES], size_nxt  [NUM_PAGES];
  logic [SLOT_W-1:0]  fhead_r [NUM_PAGES], fhead_nxt [NUM_PAGES];
  logic [LINK_W-1:0]  next_r  [NUM_PAGES], next_nxt  [NUM_PAGES];
  logic [LINK_W-1:0]  prev_r  [NUM_PAGES], prev_nxt  [NUM_PAGES];
  logic [LINK_W-1:0]  head_r  [3],         head_nxt  [3];

  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;
  logic [1:0]         out_user_r, out_user_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [SLOT_W-1:0]  ram_wdata, ram_rdata;

  logic               any_free, carve_go, pop_full, pop_move, free_ok, free_full;
  logic               recl_go, ofs_go;
  logic [PAGE_W-1:0]  low_free, q_o;
  logic [OFS_W-1:0]   ofs_val;
  logic [CNT_W-1:0]   inuse_inc;

  soa_geom u_geom (
    .cfg  (cfg_r),
    .geom (geom)
  );

  soa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_PAGES * MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    any_free = 1'b0;
    low_free = '0;
    for (int i = NUM_PAGES - 1; i >= 0; i--) begin
      if (!owned_r[i]) begin
        any_free = 1'b1;
        low_free = PAGE_W'(i);
      end
    end
  end

  assign inuse_inc = inuse_r[p_r] + CNT_W'(1);
  assign carve_go  = (geom.size != '0) && (acc_r <= ACC_W'(PAGE_BYTES)) &&
                     (i_r < CNT_W'(MAX_SLOTS));
  assign pop_full  = inuse_inc >= total_r[p_r];
  assign pop_move  = pop_full || (kind_r[p_r] == KIND_FREE);
  assign free_ok   = owned_r[fp_r] && (CNT_W'(s_r) < total_r[fp_r]) &&
                     (inuse_r[fp_r] != '0);
  assign free_full = inuse_r[fp_r] == total_r[fp_r];
  assign recl_go   = (emp_r > 5'd1) && !head_r[head_idx(KIND_FREE)][LINK_W-1];
  assign ofs_go    = !out_valid_r || out_tready;
  assign q_o       = (op_r == OP_FREE) ? fp_r : p_r;
  assign ofs_val   = OFS_W'(first_r[q_o]) + OFS_W'(s_r * size_r[q_o]);

  assign in_tready  = state_r == ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = (in_tuser[0] == OP_FREE) ? ST_FCHK : ST_ASEL;
      ST_ASEL: begin
        if (!head_r[head_idx(KIND_PARTIAL)][LINK_W-1] ||
            !head_r[head_idx(KIND_FREE)][LINK_W-1]) begin
          state_nxt = ST_POPRD;
        end else begin
          state_nxt = any_free ? ST_CARVE : ST_OFS;
        end
      end
      ST_CARVE: if (!carve_go) state_nxt = (i_r == '0) ? ST_OFS : ST_RM;
      ST_POPRD: state_nxt = ST_POP;
      ST_POP:   state_nxt = pop_move ? ST_RM : ST_OFS;
      ST_RM:    state_nxt = ins_r ? ST_INS : ret_r;
      ST_INS:   state_nxt = ret_r;
      ST_FCHK: begin
        if (!free_ok) state_nxt = ST_OFS;
        else          state_nxt = free_full ? ST_RM : ST_FDEC;
      end
      ST_FDEC:  state_nxt = (inuse_r[p_r] == CNT_W'(1)) ? ST_RM : ST_OFS;
      ST_FEMP:  state_nxt = ST_RECL;
      ST_RECL:  state_nxt = recl_go ? ST_RM : ST_OFS;
      ST_OFS:   if (ofs_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [LINK_W-1:0] n, v, h;
    n = '0;
    v = '0;
    h = '0;
    cfg_nxt = cfg_r;
    op_nxt = op_r;
    ins_nxt = ins_r;
    ret_nxt = ret_r;
    tgt_nxt = tgt_r;
    fp_nxt = fp_r;
    p_nxt = p_r;
    s_nxt = s_r;
    i_nxt = i_r;
    acc_nxt = acc_r;
    emp_nxt = emp_r;
    stat_nxt = stat_r;
    owned_nxt = owned_r;
    kind_nxt = kind_r;
    inuse_nxt = inuse_r;
    total_nxt = total_r;
    first_nxt = first_r;
    size_nxt = size_r;
    fhead_nxt = fhead_r;
    next_nxt = next_r;
    prev_nxt = prev_r;
    head_nxt = head_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    ram_we = 1'b0;
    ram_waddr = {p_r, i_r[SLOT_W-1:0]};
    ram_wdata = '0;
    ram_raddr = {p_r, fhead_r[p_r]};

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_OBJECT: cfg_nxt.object_bytes = cfg_data;
        REG_ALIGN:  cfg_nxt.align_bytes  = cfg_data;
        REG_HEADER: cfg_nxt.header_bytes = cfg_data[8:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser[0];
          fp_nxt = in_tdata[PAGE_W-1:0];
          s_nxt  = in_tdata[PAGE_W +: SLOT_W];
        end
      end
      ST_ASEL: begin
        stat_nxt = STATUS_OK;
        if (!head_r[head_idx(KIND_PARTIAL)][LINK_W-1]) begin
          p_nxt = head_r[head_idx(KIND_PARTIAL)][PAGE_W-1:0];
        end else if (!head_r[head_idx(KIND_FREE)][LINK_W-1]) begin
          p_nxt = head_r[head_idx(KIND_FREE)][PAGE_W-1:0];
        end else if (any_free) begin
          p_nxt   = low_free;
          i_nxt   = '0;
          acc_nxt = ACC_W'(geom.first) + ACC_W'(geom.size);
        end else begin
          stat_nxt = STATUS_NOMEM;
        end
      end
      ST_CARVE: begin
        if (carve_go) begin
          ram_we    = 1'b1;
          ram_wdata = (i_r == '0) ? '0 : SLOT_W'(i_r - CNT_W'(1));
          i_nxt     = i_r + CNT_W'(1);
          acc_nxt   = acc_r + ACC_W'(geom.size);
        end else if (i_r == '0) begin
          stat_nxt = STATUS_NOMEM;
        end else begin
          owned_nxt[p_r] = 1'b1;
          inuse_nxt[p_r] = '0;
          total_nxt[p_r] = i_r;
          first_nxt[p_r] = geom.first;
          size_nxt[p_r]  = geom.size;
          fhead_nxt[p_r] = SLOT_W'(i_r - CNT_W'(1));
          kind_nxt[p_r]  = KIND_NONE;
          emp_nxt        = emp_r + 5'd1;
          tgt_nxt        = KIND_FREE;
          ins_nxt        = 1'b1;
          ret_nxt        = ST_POPRD;
        end
      end
      ST_POPRD: begin
        s_nxt = fhead_r[p_r];
      end
      ST_POP: begin
        fhead_nxt[p_r] = ram_rdata;
        inuse_nxt[p_r] = inuse_inc;
        ins_nxt = 1'b1;
        ret_nxt = ST_OFS;
        tgt_nxt = pop_full ? KIND_FULL : KIND_PARTIAL;
        if ((kind_r[p_r] == KIND_FREE) && (emp_r != '0)) begin
          emp_nxt = emp_r - 5'd1;
        end
      end
      ST_RM: begin
        if (kind_r[p_r] != KIND_NONE) begin
          n = next_r[p_r];
          v = prev_r[p_r];
          if (v[LINK_W-1]) head_nxt[head_idx(kind_r[p_r])] = n;
          else             next_nxt[v[PAGE_W-1:0]] = n;
          if (!n[LINK_W-1]) prev_nxt[n[PAGE_W-1:0]] = v;
          kind_nxt[p_r] = KIND_NONE;
        end
      end
      ST_INS: begin
        h = head_r[head_idx(tgt_r)];
        next_nxt[p_r] = h;
        prev_nxt[p_r] = LINK_NIL;
        if (!h[LINK_W-1]) prev_nxt[h[PAGE_W-1:0]] = {1'b0, p_r};
        head_nxt[head_idx(tgt_r)] = {1'b0, p_r};
        kind_nxt[p_r] = tgt_r;
      end
      ST_FCHK: begin
        if (free_ok) begin
          stat_nxt        = STATUS_OK;
          p_nxt           = fp_r;
          ram_we          = 1'b1;
          ram_waddr       = {fp_r, s_r};
          ram_wdata       = fhead_r[fp_r];
          fhead_nxt[fp_r] = s_r;
          tgt_nxt         = KIND_PARTIAL;
          ins_nxt         = 1'b1;
          ret_nxt         = ST_FDEC;
        end else begin
          stat_nxt = STATUS_BAD;
        end
      end
      ST_FDEC: begin
        inuse_nxt[p_r] = inuse_r[p_r] - CNT_W'(1);
        tgt_nxt = KIND_FREE;
        ins_nxt = 1'b1;
        ret_nxt = ST_FEMP;
      end
      ST_FEMP: begin
        emp_nxt = emp_r + 5'd1;
      end
      ST_RECL: begin
        if (recl_go) begin
          p_nxt = head_r[head_idx(KIND_FREE)][PAGE_W-1:0];
          owned_nxt[head_r[head_idx(KIND_FREE)][PAGE_W-1:0]] = 1'b0;
          emp_nxt = emp_r - 5'd1;
          ins_nxt = 1'b0;
          ret_nxt = ST_RECL;
        end
      end
      ST_OFS: begin
        if (ofs_go) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = stat_r;
          if (stat_r == STATUS_OK) begin
            out_data_nxt = {7'd0, ofs_val, s_r, q_o};
          end else begin
            out_data_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      emp_r       <= '0;
      cfg_r       <= '{object_bytes: 13'd64, align_bytes: 13'd8, header_bytes: 9'd48};
      for (int i = 0; i < NUM_PAGES; i++) begin
        owned_r[i] <= 1'b0;
        kind_r[i]  <= KIND_NONE;
        inuse_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= LINK_NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      emp_r       <= emp_nxt;
      cfg_r       <= cfg_nxt;
      owned_r     <= owned_nxt;
      kind_r      <= kind_nxt;
      inuse_r     <= inuse_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ins_r      <= ins_nxt;
    ret_r      <= ret_nxt;
    tgt_r      <= tgt_nxt;
    fp_r       <= fp_nxt;
    p_r        <= p_nxt;
    s_r        <= s_nxt;
    i_r        <= i_nxt;
    acc_r      <= acc_nxt;
    stat_r     <= stat_nxt;
    total_r    <= total_nxt;
    first_r    <= first_nxt;
    size_r     <= size_nxt;
    fhead_r    <= fhead_nxt;
    next_r     <= next_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_one_spare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (emp_r <= 5'd1))
    else $error("more than one empty slab kept");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != STATUS_OK)) |-> (out_tdata == '0))
    else $error("failed result carries a location");

  a_pop_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> owned_r[p_r])
    else $error("object taken from an unowned page");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for slab_object_allocator: a directed table and random
// alloc/free traffic under several cache geometries, every result compared
// with an in-bench allocator model, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;
  import soa_pkg::*;

  localparam int NIL = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  page;
    logic [8:0]  slot;
    logic [11:0] ofs;
  } alloc_result_t;

  typedef struct {
    logic          op;
    logic [3:0]    page;
    logic [8:0]    slot;
    bit            typed;
    alloc_result_t res;
  } table_row_t;

  typedef struct {
    int obj;
    int algn;
    int hdr;
    int alloc_pct;
    int ready_pct;
    int items;
  } phase_t;

  typedef struct {
    logic [3:0] page;
    logic [8:0] slot;
  } live_obj_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  slab_object_allocator uut (.*);

  always #5 clk = ~clk;

  // cache model state
  int unsigned m_obj, m_align, m_hdr;
  bit          m_owned [NUM_PAGES];
  kind_t       m_kind  [NUM_PAGES];
  int unsigned m_inuse [NUM_PAGES];
  int unsigned m_fhead [NUM_PAGES];
  int unsigned m_total [NUM_PAGES];
  int unsigned m_first [NUM_PAGES];
  int unsigned m_size  [NUM_PAGES];
  int unsigned m_snext [NUM_PAGES*MAX_SLOTS];
  int          m_next  [NUM_PAGES];
  int          m_prev  [NUM_PAGES];
  int          m_head  [3];
  int unsigned m_empty;

  alloc_result_t pending_results[$];
  live_obj_t     live_objs[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            ready_pct = 100;
  int            burst_left = 0;

  function automatic void list_unlink(int p);
    int n, v;
    if (m_kind[p] == KIND_NONE) return;
    n = m_next[p];
    v = m_prev[p];
    if (v == NIL) m_head[int'(m_kind[p]) - 1] = n;
    else m_next[v] = n;
    if (n != NIL) m_prev[n] = v;
    m_kind[p] = KIND_NONE;
  endfunction

  function automatic void list_link(int p, kind_t k);
    int h;
    h = m_head[int'(k) - 1];
    list_unlink(p);
    m_next[p] = h;
    m_prev[p] = NIL;
    if (h != NIL) m_prev[h] = p;
    m_head[int'(k) - 1] = p;
    m_kind[p] = k;
  endfunction

  function automatic alloc_result_t alloc_object();
    alloc_result_t r;
    int p, h;
    int unsigned a, b, sz, fst, cnt, s;
    kind_t k;
    h = m_head[int'(KIND_PARTIAL) - 1];
    if (h == NIL) h = m_head[int'(KIND_FREE) - 1];
    if (h != NIL) begin
      p = h;
    end else begin
      a = m_align;
      b = 1;
      if (a == 0) b = 8;
      else while ((b << 1) <= a) b = b << 1;
      a = b;
      for (p = 0; p < NUM_PAGES; p++) if (!m_owned[p]) break;
      sz  = (m_obj + a - 1) & ~(a - 1);
      fst = (m_hdr + a - 1) & ~(a - 1);
      cnt = 0;
      if (sz != 0 && fst + sz <= PAGE_BYTES) cnt = (PAGE_BYTES - fst) / sz;
      if (cnt > MAX_SLOTS) cnt = MAX_SLOTS;
      if (p >= NUM_PAGES || cnt == 0) begin
        r = '0;
        r.status = STATUS_NOMEM;
        return r;
      end
      m_owned[p] = 1'b1;
      m_inuse[p] = 0;
      m_total[p] = cnt;
      m_first[p] = fst;
      m_size[p]  = sz;
      for (int i = 0; i < cnt; i++) m_snext[p*MAX_SLOTS + i] = (i == 0) ? 0 : i - 1;
      m_fhead[p] = cnt - 1;
      m_kind[p] = KIND_NONE;
      list_link(p, KIND_FREE);
      m_empty++;
    end
    s = m_fhead[p] % MAX_SLOTS;
    m_fhead[p] = m_snext[p*MAX_SLOTS + s] % MAX_SLOTS;
    m_inuse[p]++;
    k = m_kind[p];
    if (m_inuse[p] >= m_total[p]) begin
      list_link(p, KIND_FULL);
      if (k == KIND_FREE && m_empty != 0) m_empty--;
    end else if (k == KIND_FREE) begin
      list_link(p, KIND_PARTIAL);
      if (m_empty != 0) m_empty--;
    end
    r.status = STATUS_OK;
    r.page = 4'(p);
    r.slot = 9'(s);
    r.ofs  = 12'(m_first[p] + s * m_size[p]);
    return r;
  endfunction

  function automatic alloc_result_t release_object(int p, int unsigned s);
    alloc_result_t r;
    int v;
    if (!m_owned[p] || s >= m_total[p] || m_inuse[p] == 0) begin
      r = '0;
      r.status = STATUS_BAD;
      return r;
    end
    m_snext[p*MAX_SLOTS + s] = m_fhead[p];
    m_fhead[p] = s;
    if (m_inuse[p] == m_total[p]) list_link(p, KIND_PARTIAL);
    m_inuse[p]--;
    if (m_inuse[p] == 0) begin
      list_link(p, KIND_FREE);
      m_empty++;
      while (m_empty > 1) begin
        v = m_head[int'(KIND_FREE) - 1];
        if (v == NIL) break;
        list_unlink(v);
        m_owned[v] = 1'b0;
        m_empty--;
      end
    end
    r.status = STATUS_OK;
    r.page = 4'(p);
    r.slot = 9'(s);
    r.ofs  = 12'(m_first[p] + s * m_size[p]);
    return r;
  endfunction

  // sink stall pattern, watchdog and result check
  always @(posedge clk) begin
    alloc_result_t got, want;
    out_tready <= ($urandom_range(0, 99) < ready_pct);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** slab_object_allocator: FAILED **");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.page   = out_tdata[3:0];
      got.slot   = out_tdata[12:4];
      got.ofs    = out_tdata[24:13];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 13'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OBJECT: m_obj   = val & 13'h1FFF;
      REG_ALIGN:  m_align = val & 13'h1FFF;
      REG_HEADER: m_hdr   = val & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [3:0] pg, logic [8:0] sl, bit typed,
                           alloc_result_t typed_res);
    alloc_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, sl, pg};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    r = (op == OP_ALLOC) ? alloc_object() : release_object(pg, sl);
    if (op == OP_ALLOC && r.status == STATUS_OK) live_objs.push_back('{r.page, r.slot});
    pending_results.push_back(typed ? typed_res : r);
  endtask

  table_row_t directed [12] = '{
    '{OP_FREE,  4'd0,  9'd0,   1, '{STATUS_BAD, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd15, 9'd511, 1, '{STATUS_BAD, 4'd0, 9'd0, 12'd0}},
    '{OP_ALLOC, 4'd15, 9'd511, 1, '{STATUS_OK, 4'd0, 9'd62, 12'd4016}},
    '{OP_ALLOC, 4'd0,  9'd0,   0, '{STATUS_OK, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd0,  9'd63,  1, '{STATUS_BAD, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd1,  9'd0,   1, '{STATUS_BAD, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd0,  9'd62,  0, '{STATUS_OK, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd0,  9'd62,  0, '{STATUS_OK, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd0,  9'd61,  1, '{STATUS_BAD, 4'd0, 9'd0, 12'd0}},
    '{OP_ALLOC, 4'd0,  9'd0,   0, '{STATUS_OK, 4'd0, 9'd0, 12'd0}},
    '{OP_ALLOC, 4'd0,  9'd0,   0, '{STATUS_OK, 4'd0, 9'd0, 12'd0}},
    '{OP_FREE,  4'd0,  9'd62,  0, '{STATUS_OK, 4'd0, 9'd0, 12'd0}}
  };

  phase_t phases [9] = '{
    '{8,    8,    0,   80, 100, 80},
    '{4096, 8,    0,   85, 60,  60},
    '{4096, 4096, 256, 60, 25,  60},
    '{0,    0,    0,   60, 100, 60},
    '{100,  24,   256, 60, 60,  90},
    '{8191, 8191, 511, 30, 100, 60},
    '{1024, 256,  200, 55, 25,  90},
    '{-1,   -1,   -1,  50, 60,  100},
    '{64,   8,    48,  20, 100, 100}
  };

  initial begin
    alloc_result_t none;
    int r, k;
    live_obj_t lo;
    none = '0;
    m_obj = 64; m_align = 8; m_hdr = 48; m_empty = 0;
    foreach (m_owned[i]) begin
      m_owned[i] = 0; m_kind[i] = KIND_NONE; m_inuse[i] = 0; m_fhead[i] = 0;
      m_total[i] = 0; m_first[i] = 0; m_size[i] = 0; m_next[i] = 0; m_prev[i] = 0;
    end
    foreach (m_snext[i]) m_snext[i] = 0;
    foreach (m_head[i]) m_head[i] = NIL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_item(directed[i].op, directed[i].page, directed[i].slot,
                directed[i].typed, directed[i].res);
    foreach (phases[p]) begin
      drain();
      ready_pct = phases[p].ready_pct;
      write_reg(REG_OBJECT, phases[p].obj < 0 ? $urandom_range(1, 600) : phases[p].obj);
      write_reg(REG_ALIGN, phases[p].algn < 0 ? (1 << $urandom_range(3, 7)) : phases[p].algn);
      write_reg(REG_HEADER, phases[p].hdr < 0 ? $urandom_range(0, 256) : phases[p].hdr);
      cfg_valid <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < phases[p].items; n++) begin
        if (p == 4 && n == phases[p].items / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_item(1'($urandom), 4'($urandom), 9'($urandom), 0, none);
        end else if (live_objs.size() == 0 || $urandom_range(0, 99) < phases[p].alloc_pct) begin
          send_item(OP_ALLOC, 4'($urandom), 9'($urandom), 0, none);
        end else begin
          k = $urandom_range(0, live_objs.size() - 1);
          lo = live_objs[k];
          live_objs.delete(k);
          send_item(OP_FREE, lo.page, lo.slot, 0, none);
        end
      end
    end
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** slab_object_allocator: PASSED **");
    else
      $display("** slab_object_allocator: FAILED **");
    $finish;
  end

endmodule
